### src/szsl_pkg.sv
// ---------------------------------------------------------------------------
// szsl_pkg: shared definitions for the scan zone speed limiter
// Reset values, register codes, the CORDIC arctangent table, zone limits
// and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none

package szsl_pkg;

  // Default width of the range samples that are used.
  localparam int RANGE_BITS_DEF = 16;

  // Rotation steps of the CORDIC, digit steps of the square root.
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 9;

  // CORDIC gain in Q16.
  localparam logic [15:0] GAIN_Q16 = 16'd39797;

  // Register reset values.
  localparam logic [15:0] START_ANGLE_RST = 16'hC000;
  localparam logic [12:0] ANGLE_STEP_RST  = 13'd45;
  localparam logic [15:0] MIN_RANGE_RST   = 16'd200;
  localparam logic [13:0] DEF_LIMIT_RST   = 14'd500;
  localparam logic [13:0] RAMP_STEP_RST   = 14'd10;
  localparam logic [13:0] PREV_LIMIT_RST  = 14'd100;

  // Speed caps of the zones, mm/s.
  localparam logic [13:0] CAP_FREE       = 14'd10000;
  localparam logic [13:0] CAP_VERY_CLOSE = 14'd10;
  localparam logic [13:0] CAP_REAR_VNEAR = 14'd100;
  localparam logic [13:0] CAP_REAR_NEAR  = 14'd300;
  localparam logic [13:0] FOLLOW_OFFSET  = 14'd50;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_START_ANGLE = 3'd0,
    REG_ANGLE_STEP  = 3'd1,
    REG_MIN_RANGE   = 3'd2,
    REG_DEF_LIMIT   = 3'd3,
    REG_RAMP_STEP   = 3'd4
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_LOAD,
    S_ROT,
    S_ZONE,
    S_SQRT,
    S_DONE
  } state_t;

  // Arctangent of 2^-i in 1/65536 turn units.
  function automatic logic [13:0] atan_turns(input logic [3:0] i);
    logic [13:0] v;
    begin
      case (i)
        4'd0:    v = 14'd8192;
        4'd1:    v = 14'd4836;
        4'd2:    v = 14'd2555;
        4'd3:    v = 14'd1297;
        4'd4:    v = 14'd651;
        4'd5:    v = 14'd326;
        4'd6:    v = 14'd163;
        4'd7:    v = 14'd81;
        4'd8:    v = 14'd41;
        4'd9:    v = 14'd20;
        4'd10:   v = 14'd10;
        4'd11:   v = 14'd5;
        4'd12:   v = 14'd3;
        4'd13:   v = 14'd1;
        4'd14:   v = 14'd1;
        default: v = 14'd0;
      endcase
      return v;
    end
  endfunction

endpackage

`default_nettype wire

### src/scan_zone_speed_limiter.sv
// ---------------------------------------------------------------------------
// scan_zone_speed_limiter: speed cap from one lidar scan
// Turns range samples into points, sorts them into speed zones and gives
// one ramp-limited speed limit per scan.
// ---------------------------------------------------------------------------
// The block takes one range word at a time and holds in_stall high while it
// works on it. A word whose range is at or below min_range goes from the
// accept step straight to the update step. Any other word runs through the
// accept step, a bit-serial multiply of its RANGE_BITS range bits by the
// CORDIC gain, one load step, sixteen CORDIC rotation steps on the same
// shifters and adders, one zone decision and one update step. A point in the
// front follow zone adds the square root steps, which take two radicand bits
// and give one root bit a cycle. The speed limit of a scan appears as one
// out_speed_cap word after the word marked last_sample; it sits in an output
// register, so the block goes on taking words while that result waits, and
// only stalls at the end of the next scan if the result is still not taken.
// Registers are written through the APB-style port at byte address 4*i; new
// start_angle and default_limit values take effect at the next scan reload.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_zone_speed_limiter #(
  parameter int RANGE_BITS = szsl_pkg::RANGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [RANGE_BITS-1:0] in_range_mm,
  input  wire logic                  in_last_sample,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [13:0]                out_speed_cap,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [4:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Product of range and gain, and the CORDIC vector width. The vector
  // length after rotation is about range * 2^14, so this leaves headroom.
  localparam int PW   = RANGE_BITS + 16;
  localparam int CW   = PW;
  localparam int XW   = CW - 14;
  localparam int ZW   = 18;
  localparam int CMPW = (RANGE_BITS > 16) ? RANGE_BITS : 16;
  localparam int CNTW = $clog2((RANGE_BITS > 16) ? RANGE_BITS : 16);
  localparam int RADW = 18;
  localparam int REMW = 12;

  // Configuration registers.
  logic [15:0] start_angle_r;
  logic [12:0] angle_step_r;
  logic [15:0] min_range_r;
  logic [13:0] def_limit_r;
  logic [13:0] ramp_step_r;

  // Scan state.
  logic [13:0] running_min_r, running_min_nxt;
  logic [15:0] cur_angle_r, cur_angle_nxt;
  logic [13:0] prev_limit_r, prev_limit_nxt;

  // Sequencer.
  szsl_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  // Word datapath.
  logic [RANGE_BITS-1:0] rng_sr_r, rng_sr_nxt;
  logic [PW-1:0]         acc_r, acc_nxt;
  logic signed [CW-1:0]  x_r, x_nxt;
  logic signed [CW-1:0]  y_r, y_nxt;
  logic signed [ZW-1:0]  z_r, z_nxt;
  logic                  flip_r, flip_nxt;
  logic                  last_r, last_nxt;
  logic [13:0]           cap_r, cap_nxt;
  logic                  cap_v_r, cap_v_nxt;
  logic [RADW-1:0]       rad_r, rad_nxt;
  logic [REMW-1:0]       rem_r, rem_nxt;
  logic [8:0]            root_r, root_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [13:0] out_speed_r, out_speed_nxt;

  logic in_accept;
  logic out_free;
  logic cfg_write;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_write = psel && penable && pwrite;

  // -------------------------------------------------------------------------
  // Configuration port. The register index is the word address.
  // -------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      szsl_pkg::REG_START_ANGLE: prdata = {16'd0, start_angle_r};
      szsl_pkg::REG_ANGLE_STEP:  prdata = {19'd0, angle_step_r};
      szsl_pkg::REG_MIN_RANGE:   prdata = {16'd0, min_range_r};
      szsl_pkg::REG_DEF_LIMIT:   prdata = {18'd0, def_limit_r};
      szsl_pkg::REG_RAMP_STEP:   prdata = {18'd0, ramp_step_r};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= szsl_pkg::START_ANGLE_RST;
      angle_step_r  <= szsl_pkg::ANGLE_STEP_RST;
      min_range_r   <= szsl_pkg::MIN_RANGE_RST;
      def_limit_r   <= szsl_pkg::DEF_LIMIT_RST;
      ramp_step_r   <= szsl_pkg::RAMP_STEP_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        szsl_pkg::REG_START_ANGLE: start_angle_r <= pwdata[15:0];
        szsl_pkg::REG_ANGLE_STEP:  angle_step_r  <= pwdata[12:0];
        szsl_pkg::REG_MIN_RANGE:   min_range_r   <= pwdata[15:0];
        szsl_pkg::REG_DEF_LIMIT:   def_limit_r   <= pwdata[13:0];
        szsl_pkg::REG_RAMP_STEP:   ramp_step_r   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Angle folding. Angles in the back half-plane are turned by half a turn
  // (flip the top bit) and the start vector is negated instead.
  // -------------------------------------------------------------------------
  logic        fold;
  logic [15:0] angle_fold;

  assign fold       = cur_angle_r[15] ^ cur_angle_r[14];
  assign angle_fold = fold ? {~cur_angle_r[15], cur_angle_r[14:0]} : cur_angle_r;

  // -------------------------------------------------------------------------
  // Zone decision on the integer mm point. The tests run in priority order;
  // the front follow zone hands off to the square root.
  // -------------------------------------------------------------------------
  logic signed [XW-1:0] x_mm, y_mm;
  int                   xi, yi;
  logic                 y_in300, y_in400, y_in600, x_rear;
  logic                 zone_follow;
  logic [13:0]          zone_cap;
  logic [9:0]           x_lo;
  logic [RADW-1:0]      follow_rad;

  always_comb begin
    x_mm    = x_r[CW-1:14];
    y_mm    = y_r[CW-1:14];
    xi      = int'(x_mm);
    yi      = int'(y_mm);
    y_in300 = (yi > -300) && (yi < 300);
    y_in400 = (yi > -400) && (yi < 400);
    y_in600 = (yi > -600) && (yi < 600);
    x_rear  = (xi <= 0) && (xi > -800);
    zone_follow = 1'b0;
    if ((xi < 200) && (xi > -600) && y_in300) begin
      zone_cap = szsl_pkg::CAP_FREE;
    end else if ((xi < 300) && (xi > 0) && y_in300) begin
      zone_cap = szsl_pkg::CAP_VERY_CLOSE;
    end else if ((xi < 1000) && (xi > 0) && y_in300) begin
      zone_cap    = szsl_pkg::CAP_FREE;
      zone_follow = 1'b1;
    end else if (x_rear && y_in400) begin
      zone_cap = szsl_pkg::CAP_REAR_VNEAR;
    end else if (x_rear && y_in600) begin
      zone_cap = szsl_pkg::CAP_REAR_NEAR;
    end else begin
      zone_cap = szsl_pkg::CAP_FREE;
    end
    // 250 * x as 256x - 4x - 2x; x is below 1000 here.
    x_lo       = x_mm[9:0];
    follow_rad = {x_lo, 8'd0} - {6'd0, x_lo, 2'd0} - {7'd0, x_lo, 1'b0};
  end

  // -------------------------------------------------------------------------
  // Next state.
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      szsl_pkg::S_IDLE: begin
        if (in_accept) begin
          if (CMPW'(in_range_mm) > CMPW'(min_range_r)) begin
            state_nxt = szsl_pkg::S_MUL;
          end else begin
            state_nxt = szsl_pkg::S_DONE;
          end
        end
      end
      szsl_pkg::S_MUL: begin
        if (cnt_r == CNTW'(RANGE_BITS - 1)) begin
          state_nxt = szsl_pkg::S_LOAD;
        end
      end
      szsl_pkg::S_LOAD: begin
        state_nxt = szsl_pkg::S_ROT;
      end
      szsl_pkg::S_ROT: begin
        if (cnt_r == CNTW'(szsl_pkg::CORDIC_STEPS - 1)) begin
          state_nxt = szsl_pkg::S_ZONE;
        end
      end
      szsl_pkg::S_ZONE: begin
        state_nxt = zone_follow ? szsl_pkg::S_SQRT : szsl_pkg::S_DONE;
      end
      szsl_pkg::S_SQRT: begin
        if (cnt_r == CNTW'(szsl_pkg::SQRT_STEPS - 1)) begin
          state_nxt = szsl_pkg::S_DONE;
        end
      end
      szsl_pkg::S_DONE: begin
        if (!last_r || out_free) begin
          state_nxt = szsl_pkg::S_IDLE;
        end
      end
      default: state_nxt = szsl_pkg::S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Datapath and outputs.
  // -------------------------------------------------------------------------
  logic signed [CW-1:0] dx, dy;
  logic signed [ZW-1:0] atan_ext;
  logic [REMW-1:0]      rem_sh, trial;
  logic [13:0]          min_eff;
  logic [14:0]          ceiling;

  always_comb begin
    cnt_nxt         = cnt_r;
    rng_sr_nxt      = rng_sr_r;
    acc_nxt         = acc_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    z_nxt           = z_r;
    flip_nxt        = flip_r;
    last_nxt        = last_r;
    cap_nxt         = cap_r;
    cap_v_nxt       = cap_v_r;
    rad_nxt         = rad_r;
    rem_nxt         = rem_r;
    root_nxt        = root_r;
    running_min_nxt = running_min_r;
    cur_angle_nxt   = cur_angle_r;
    prev_limit_nxt  = prev_limit_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_speed_nxt   = out_speed_r;

    dx       = y_r >>> cnt_r[3:0];
    dy       = x_r >>> cnt_r[3:0];
    atan_ext = ZW'(szsl_pkg::atan_turns(cnt_r[3:0]));
    rem_sh   = {rem_r[REMW-3:0], rad_r[RADW-1:RADW-2]};
    trial    = {1'b0, root_r, 2'b01};
    min_eff  = (cap_v_r && (cap_r < running_min_r)) ? cap_r : running_min_r;
    ceiling  = {1'b0, prev_limit_r} + {1'b0, ramp_step_r};

    unique case (state_r)
      szsl_pkg::S_IDLE: begin
        if (in_accept) begin
          rng_sr_nxt    = in_range_mm;
          last_nxt      = in_last_sample;
          acc_nxt       = '0;
          cnt_nxt       = '0;
          cap_v_nxt     = 1'b0;
          flip_nxt      = fold;
          z_nxt         = ZW'($signed(angle_fold));
          cur_angle_nxt = cur_angle_r + {3'd0, angle_step_r};
        end
      end
      szsl_pkg::S_MUL: begin
        // One range bit a cycle, most significant first.
        acc_nxt    = {acc_r[PW-2:0], 1'b0}
                   + (rng_sr_r[RANGE_BITS-1] ? PW'(szsl_pkg::GAIN_Q16) : PW'(0));
        rng_sr_nxt = {rng_sr_r[RANGE_BITS-2:0], 1'b0};
        cnt_nxt    = cnt_r + CNTW'(1);
      end
      szsl_pkg::S_LOAD: begin
        x_nxt   = flip_r ? -$signed({2'b00, acc_r[PW-1:2]})
                         :  $signed({2'b00, acc_r[PW-1:2]});
        y_nxt   = '0;
        cnt_nxt = '0;
      end
      szsl_pkg::S_ROT: begin
        if (!z_r[ZW-1]) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_ext;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_ext;
        end
        cnt_nxt = cnt_r + CNTW'(1);
      end
      szsl_pkg::S_ZONE: begin
        cap_nxt   = zone_cap;
        cap_v_nxt = !zone_follow;
        rad_nxt   = follow_rad;
        rem_nxt   = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
      end
      szsl_pkg::S_SQRT: begin
        // Restoring square root, two radicand bits a cycle.
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[7:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[7:0], 1'b0};
        end
        rad_nxt = {rad_r[RADW-3:0], 2'b00};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(szsl_pkg::SQRT_STEPS - 1)) begin
          cap_nxt   = {5'd0, root_nxt} + szsl_pkg::FOLLOW_OFFSET;
          cap_v_nxt = 1'b1;
        end
      end
      szsl_pkg::S_DONE: begin
        if (!last_r) begin
          running_min_nxt = min_eff;
        end else if (out_free) begin
          // Clamp the rise over the previous limit to the ramp step.
          if ({1'b0, min_eff} > ceiling) begin
            out_speed_nxt = ceiling[13:0];
          end else begin
            out_speed_nxt = min_eff;
          end
          out_valid_nxt   = 1'b1;
          prev_limit_nxt  = out_speed_nxt;
          running_min_nxt = def_limit_r;
          cur_angle_nxt   = start_angle_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall      = (state_r != szsl_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_speed_cap = out_speed_r;

  // -------------------------------------------------------------------------
  // Registers.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= szsl_pkg::S_IDLE;
      cnt_r         <= '0;
      running_min_r <= szsl_pkg::DEF_LIMIT_RST;
      cur_angle_r   <= szsl_pkg::START_ANGLE_RST;
      prev_limit_r  <= szsl_pkg::PREV_LIMIT_RST;
      out_valid_r   <= 1'b0;
      last_r        <= 1'b0;
      cap_v_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      running_min_r <= running_min_nxt;
      cur_angle_r   <= cur_angle_nxt;
      prev_limit_r  <= prev_limit_nxt;
      out_valid_r   <= out_valid_nxt;
      last_r        <= last_nxt;
      cap_v_r       <= cap_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rng_sr_r    <= rng_sr_nxt;
    acc_r       <= acc_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    flip_r      <= flip_nxt;
    cap_r       <= cap_nxt;
    rad_r       <= rad_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    out_speed_r <= out_speed_nxt;
  end

endmodule

`default_nettype wire
